// ----- rtl/swrd_pkg.sv -----
// ----------------------------------------------------------------------------
// swrd_pkg
// Shared types, codes and the CRC8 step for the register datagram master.
// ----------------------------------------------------------------------------
package swrd_pkg;

	localparam int ECHO_BYTES = 4;

	localparam logic [7:0] SYNC_BYTE   = 8'h05;
	localparam logic [7:0] MASTER_ADDR = 8'hFF;
	localparam logic [7:0] CRC_POLY    = 8'h07;

	// item modes
	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_BYTE  = 2'd2,
		MODE_TICK  = 2'd3
	} mode_t;

	// result kinds
	localparam logic KIND_TX   = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// read status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TIMEOUT   = 2'd1;
	localparam logic [1:0] ST_BAD_FRAME = 2'd2;

	// configuration register indexes
	localparam logic CFG_NODE_ADDRESS  = 1'b0;
	localparam logic CFG_REPLY_TIMEOUT = 1'b1;

	// finished read, from receiver to serializer
	typedef struct packed {
		logic        valid;
		logic [1:0]  status;
		logic [31:0] value;
	} done_t;

	// one byte into the CRC, LSB first, poly 0x07
	function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			if (c[7] ^ b[i]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/swrd_rx.sv -----
// ----------------------------------------------------------------------------
// swrd_rx
// Reply receiver: skips the echo, checks header and CRC, counts timeout ticks.
// ----------------------------------------------------------------------------
module swrd_rx (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [1:0]           mode,
	input  logic [7:0]           rx_byte,
	input  logic [15:0]          reply_timeout,
	output swrd_pkg::done_t      done
);

	localparam logic [3:0] ECHO = 4'(swrd_pkg::ECHO_BYTES);

	logic        pending_q, pending_n;
	logic [3:0]  count_q, count_n;
	logic [7:0]  crc_q, crc_n;
	logic        hdr_good_q, hdr_good_n;
	logic [31:0] data_q, data_n;
	logic [15:0] ticks_q, ticks_n;
	logic [3:0]  rpos;
	swrd_pkg::done_t done_n;

	always_comb begin
		pending_n  = pending_q;
		count_n    = count_q;
		crc_n      = crc_q;
		hdr_good_n = hdr_good_q;
		data_n     = data_q;
		ticks_n    = ticks_q;
		done_n     = '0;
		rpos       = count_q - ECHO;
		case (swrd_pkg::mode_t'(mode))
			swrd_pkg::MODE_READ: begin
				pending_n  = 1'b1;
				count_n    = '0;
				crc_n      = '0;
				hdr_good_n = 1'b1;
				data_n     = '0;
				ticks_n    = '0;
			end
			swrd_pkg::MODE_BYTE: begin
				if (pending_q) begin
					if (count_q < ECHO) begin
						count_n = count_q + 4'd1;
					end else begin
						if (rpos == 4'd0 && rx_byte != swrd_pkg::SYNC_BYTE)
							hdr_good_n = 1'b0;
						if (rpos == 4'd1 && rx_byte != swrd_pkg::MASTER_ADDR)
							hdr_good_n = 1'b0;
						if (rpos >= 4'd3 && rpos <= 4'd6)
							data_n = {data_q[23:0], rx_byte};
						if (rpos < 4'd7) begin
							crc_n   = swrd_pkg::crc8_add(crc_q, rx_byte);
							count_n = count_q + 4'd1;
						end else begin
							// CRC beat closes the reply
							pending_n   = 1'b0;
							done_n.valid = 1'b1;
							if (hdr_good_n && rx_byte == crc_q) begin
								done_n.status = swrd_pkg::ST_OK;
								done_n.value  = data_n;
							end else begin
								done_n.status = swrd_pkg::ST_BAD_FRAME;
							end
						end
					end
				end
			end
			swrd_pkg::MODE_TICK: begin
				if (pending_q) begin
					ticks_n = ticks_q + 16'd1;
					if (ticks_n >= reply_timeout) begin
						pending_n     = 1'b0;
						done_n.valid  = 1'b1;
						done_n.status = swrd_pkg::ST_TIMEOUT;
					end
				end
			end
			default: ;
		endcase
	end

	assign done = accept ? done_n : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= 1'b0;
			count_q    <= '0;
			crc_q      <= '0;
			hdr_good_q <= 1'b1;
			data_q     <= '0;
			ticks_q    <= '0;
		end else if (accept) begin
			pending_q  <= pending_n;
			count_q    <= count_n;
			crc_q      <= crc_n;
			hdr_good_q <= hdr_good_n;
			data_q     <= data_n;
			ticks_q    <= ticks_n;
		end
	end

endmodule

// ----- rtl/swrd_tx.sv -----
// ----------------------------------------------------------------------------
// swrd_tx
// Result register and frame serializer: one beat per cycle while out_ready is high, CRC built on the fly.
// ----------------------------------------------------------------------------
module swrd_tx (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [1:0]      mode,
	input  logic [6:0]      reg_index,
	input  logic [31:0]     write_value,
	input  logic [7:0]      node_address,
	input  swrd_pkg::done_t done,
	input  logic            out_ready,
	output logic            free,
	output logic            out_valid,
	output logic            out_kind,
	output logic [7:0]      tx_byte,
	output logic            last_byte,
	output logic [1:0]      read_status,
	output logic [31:0]     read_value
);

	logic        busy_q;
	logic        kind_q;
	logic [55:0] frame_q;   // pending frame bytes, next one on top
	logic [2:0]  rem_q;     // frame bytes left before the CRC beat
	logic [7:0]  crc_q;
	logic [1:0]  status_q;
	logic [31:0] value_q;
	logic        take, last_beat, load_wr, load_rd;

	assign take      = busy_q && out_ready;
	assign last_beat = (kind_q == swrd_pkg::KIND_DONE) || (rem_q == 3'd0);
	assign free      = !busy_q || (take && last_beat);
	assign load_wr   = accept && (mode == swrd_pkg::MODE_WRITE);
	assign load_rd   = accept && (mode == swrd_pkg::MODE_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			kind_q   <= swrd_pkg::KIND_TX;
			rem_q    <= '0;
			frame_q  <= '0;
			crc_q    <= '0;
			status_q <= swrd_pkg::ST_OK;
			value_q  <= '0;
		end else if (load_wr) begin
			busy_q  <= 1'b1;
			kind_q  <= swrd_pkg::KIND_TX;
			frame_q <= {swrd_pkg::SYNC_BYTE, node_address, 1'b1, reg_index, write_value};
			rem_q   <= 3'd7;
			crc_q   <= '0;
		end else if (load_rd) begin
			busy_q  <= 1'b1;
			kind_q  <= swrd_pkg::KIND_TX;
			frame_q <= {swrd_pkg::SYNC_BYTE, node_address, 1'b0, reg_index, 32'd0};
			rem_q   <= 3'd3;
			crc_q   <= '0;
		end else if (done.valid) begin
			busy_q   <= 1'b1;
			kind_q   <= swrd_pkg::KIND_DONE;
			status_q <= done.status;
			value_q  <= done.value;
		end else if (take) begin
			if (last_beat) begin
				busy_q <= 1'b0;
			end else begin
				crc_q   <= swrd_pkg::crc8_add(crc_q, frame_q[55:48]);
				frame_q <= {frame_q[47:0], 8'd0};
				rem_q   <= rem_q - 3'd1;
			end
		end
	end

	always_comb begin
		out_valid   = busy_q;
		out_kind    = kind_q;
		tx_byte     = '0;
		last_byte   = 1'b0;
		read_status = swrd_pkg::ST_OK;
		read_value  = '0;
		if (kind_q == swrd_pkg::KIND_DONE) begin
			read_status = status_q;
			read_value  = value_q;
		end else begin
			tx_byte   = (rem_q == 3'd0) ? crc_q : frame_q[55:48];
			last_byte = (rem_q == 3'd0);
		end
	end

endmodule

// ----- rtl/single_wire_register_datagram.sv -----
// ----------------------------------------------------------------------------
// single_wire_register_datagram
// Master side of a one-wire register link: request frames out, reply checked.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | mode, reg_index, write_value, rx_byte
//  out     | out_valid / out_ready| out_kind, tx_byte, last_byte, read_status,
//          |                      | read_value
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// A write request gives 8 output beats, a read request 4, one per cycle while out_ready
// is high; a line byte or tick gives none or one finished-read beat in the cycle after
// acceptance. The next item is accepted in the cycle the final beat of the previous one
// is taken, so the serializer sets the rate. Output stalls hold the beat and hold off
// input. Reset is asynchronous and leaves the link idle, no read open.
// ----------------------------------------------------------------------------
module single_wire_register_datagram (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [6:0]  reg_index,
	input  logic [31:0] write_value,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_kind,
	output logic [7:0]  tx_byte,
	output logic        last_byte,
	output logic [1:0]  read_status,
	output logic [31:0] read_value,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic            accept;
	logic            free;
	logic [7:0]      node_address_q;
	logic [15:0]     reply_timeout_q;
	swrd_pkg::done_t done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q  <= 8'd0;
			reply_timeout_q <= 16'd20;
		end else if (cfg_we) begin
			if (cfg_index == swrd_pkg::CFG_NODE_ADDRESS)
				node_address_q <= cfg_data[7:0];
			if (cfg_index == swrd_pkg::CFG_REPLY_TIMEOUT)
				reply_timeout_q <= cfg_data;
		end
	end

	assign in_ready = free;
	assign accept   = in_valid && free;

	swrd_rx u_rx (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.mode          (mode),
		.rx_byte       (rx_byte),
		.reply_timeout (reply_timeout_q),
		.done          (done)
	);

	swrd_tx u_tx (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.mode         (mode),
		.reg_index    (reg_index),
		.write_value  (write_value),
		.node_address (node_address_q),
		.done         (done),
		.out_ready    (out_ready),
		.free         (free),
		.out_valid    (out_valid),
		.out_kind     (out_kind),
		.tx_byte      (tx_byte),
		.last_byte    (last_byte),
		.read_status  (read_status),
		.read_value   (read_value)
	);

	// a request always opens its frame with the sync byte
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (mode == swrd_pkg::MODE_WRITE || mode == swrd_pkg::MODE_READ)) |=>
		(out_valid && out_kind == swrd_pkg::KIND_TX &&
		 tx_byte == swrd_pkg::SYNC_BYTE && !last_byte))
		else $error("request did not start with sync beat");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_kind == swrd_pkg::KIND_DONE) |->
		(tx_byte == 8'd0 && !last_byte && read_status != 2'd3))
		else $error("finished-read beat carries frame fields");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && read_status != swrd_pkg::ST_OK) |-> (read_value == 32'd0))
		else $error("failed read returned a value");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input taken while a beat is stalled");

endmodule
